// ===== sv/lpg_pkg.sv =====
// Shared constants, types and helpers for the line pixel generator.
// No dependencies; every other file depends on this package.
package lpg_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int SCREEN_BITS    = 15;
  localparam int COLOR_BITS     = 32;
  localparam int CFG_IDX_BITS   = 1;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 15'd640;
  localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 15'd480;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_type_t;

  // Command word: kind, start point, end point, |dx|, -|dy|, error, step signs, color
  function automatic int cmd_bits(input int cb);
    return 1 + 4 * cb + 2 * (cb + 2) + (cb + 3) + 2 + COLOR_BITS;
  endfunction

endpackage

// ===== sv/lpg_if.sv =====
// Channel interfaces of the line pixel generator: request, pixel result, config write.
// Depends on lpg_pkg.
interface lpg_in_if #(parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [lpg_pkg::COLOR_BITS-1:0] line_color;

  modport source (output valid, req_type, start_x, start_y, end_x, end_y, line_color,
                  input ready);
  modport sink   (input valid, req_type, start_x, start_y, end_x, end_y, line_color,
                  output ready);
endinterface

interface lpg_out_if #(parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [lpg_pkg::COLOR_BITS-1:0] pixel_color;
  logic                         visible;
  logic                         last;
  logic                         idle;

  modport source (output valid, pixel_x, pixel_y, pixel_color, visible, last, idle,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, visible, last, idle,
                  output ready);
endinterface

interface lpg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [lpg_pkg::CFG_IDX_BITS-1:0]   index;
  logic [lpg_pkg::SCREEN_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/lpg_front.sv =====
// Front end: accepts request beats, classifies load vs. step, precomputes line setup.
// Depends on lpg_pkg and lpg_in_if.
module lpg_front #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  lpg_in_if.sink                                   in_bus,
  output logic                                     push_valid,
  input  logic                                     push_ready,
  output logic [lpg_pkg::cmd_bits(COORD_BITS)-1:0] push_data
);
  import lpg_pkg::*;

  localparam int CB = COORD_BITS;

  logic signed [CB:0]   ddx, ddy;
  logic signed [CB+1:0] ddx_ext, ddy_ext, abs_dx, neg_abs_dy;
  logic signed [CB+2:0] err_init;
  logic                 is_load, step_x_neg, step_y_neg;

  always_comb begin
    ddx        = {in_bus.end_x[CB-1], in_bus.end_x} - {in_bus.start_x[CB-1], in_bus.start_x};
    ddy        = {in_bus.end_y[CB-1], in_bus.end_y} - {in_bus.start_y[CB-1], in_bus.start_y};
    ddx_ext    = {ddx[CB], ddx};
    ddy_ext    = {ddy[CB], ddy};
    abs_dx     = ddx[CB] ? -ddx_ext : ddx_ext;
    neg_abs_dy = ddy[CB] ? ddy_ext : -ddy_ext;
    err_init   = {abs_dx[CB+1], abs_dx} + {neg_abs_dy[CB+1], neg_abs_dy};
    step_x_neg = !($signed(in_bus.start_x) < $signed(in_bus.end_x));
    step_y_neg = !($signed(in_bus.start_y) < $signed(in_bus.end_y));
    is_load    = (req_type_t'(in_bus.req_type) == REQ_LOAD);
  end

  assign push_valid   = in_bus.valid;
  assign in_bus.ready = push_ready;
  assign push_data    = {is_load, in_bus.start_x, in_bus.start_y, in_bus.end_x, in_bus.end_y,
                         abs_dx, neg_abs_dy, err_init, step_x_neg, step_y_neg,
                         in_bus.line_color};

endmodule

// ===== sv/lpg_queue.sv =====
// Short command queue between the front end and the stepping engine.
// Depends on lpg_pkg for the default depth.
module lpg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lpg_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);
  import lpg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/lpg_back.sv =====
// Stepping engine: holds the line state, runs the error rule, drives the result register.
// Depends on lpg_pkg and lpg_out_if.
module lpg_back #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     q_valid,
  input  logic [lpg_pkg::cmd_bits(COORD_BITS)-1:0] q_data,
  output logic                                     q_pop,
  input  logic [lpg_pkg::SCREEN_BITS-1:0]          screen_width,
  input  logic [lpg_pkg::SCREEN_BITS-1:0]          screen_height,
  lpg_out_if.source                                out_bus
);
  import lpg_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int VW = CB + SCREEN_BITS;

  // unpacked command
  logic                   c_load, c_sxn, c_syn;
  logic [CB-1:0]          c_x1, c_y1, c_x2, c_y2;
  logic signed [CB+1:0]   c_dx, c_ndy;
  logic signed [CB+2:0]   c_err;
  logic [COLOR_BITS-1:0]  c_color;

  assign {c_load, c_x1, c_y1, c_x2, c_y2, c_dx, c_ndy, c_err, c_sxn, c_syn, c_color} = q_data;

  logic [CB-1:0]         cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt, goal_x_r, goal_y_r;
  logic signed [CB+1:0]  dx_r, ndy_r;
  logic signed [CB+2:0]  err_r, err_nxt;
  logic                  sxn_r, syn_r, active_r, active_nxt;
  logic [COLOR_BITS-1:0] color_r;

  logic                  out_valid_r, out_valid_nxt;
  logic [CB-1:0]         out_x_r, out_y_r;
  logic [COLOR_BITS-1:0] out_color_r;
  logic                  out_vis_r, out_last_r, out_idle_r;

  logic                  out_free, load_pop, step_pop, fin, vis, move_x, move_y;
  logic signed [CB+3:0]  e2;

  assign out_free = !out_valid_r || out_bus.ready;
  assign q_pop    = q_valid && (c_load || out_free);
  assign load_pop = q_pop && c_load;
  assign step_pop = q_pop && !c_load;

  always_comb begin
    fin    = (cur_x_r == goal_x_r) && (cur_y_r == goal_y_r);
    vis    = !cur_x_r[CB-1] && (VW'(cur_x_r) < VW'(screen_width)) &&
             !cur_y_r[CB-1] && (VW'(cur_y_r) < VW'(screen_height));
    e2     = {err_r, 1'b0};
    move_x = e2 >= $signed({{2{ndy_r[CB+1]}}, ndy_r});
    move_y = e2 <= $signed({{2{dx_r[CB+1]}}, dx_r});
  end

  always_comb begin
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    err_nxt    = err_r;
    active_nxt = active_r;
    if (load_pop) begin
      cur_x_nxt  = c_x1;
      cur_y_nxt  = c_y1;
      err_nxt    = c_err;
      active_nxt = 1'b1;
    end else if (step_pop && active_r) begin
      if (fin) begin
        active_nxt = 1'b0;
      end else begin
        err_nxt = err_r + (move_x ? {ndy_r[CB+1], ndy_r} : '0)
                        + (move_y ? {dx_r[CB+1], dx_r} : '0);
        if (move_x) begin
          cur_x_nxt = sxn_r ? cur_x_r - 1'b1 : cur_x_r + 1'b1;
        end
        if (move_y) begin
          cur_y_nxt = syn_r ? cur_y_r - 1'b1 : cur_y_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    err_r   <= err_nxt;
    if (load_pop) begin
      goal_x_r <= c_x2;
      goal_y_r <= c_y2;
      dx_r     <= c_dx;
      ndy_r    <= c_ndy;
      sxn_r    <= c_sxn;
      syn_r    <= c_syn;
      color_r  <= c_color;
    end
    if (step_pop) begin
      out_x_r     <= active_r ? cur_x_r : '0;
      out_y_r     <= active_r ? cur_y_r : '0;
      out_color_r <= active_r ? color_r : '0;
      out_vis_r   <= active_r && vis;
      out_last_r  <= active_r && fin;
      out_idle_r  <= !active_r;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.pixel_x     = out_x_r;
  assign out_bus.pixel_y     = out_y_r;
  assign out_bus.pixel_color = out_color_r;
  assign out_bus.visible     = out_vis_r;
  assign out_bus.last        = out_last_r;
  assign out_bus.idle        = out_idle_r;

  a_pop_needs_slot: assert property (@(posedge clk) disable iff (!rst_n)
    step_pop |-> out_free)
    else $error("step command popped while result register is held");

  a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    step_pop |=> out_valid_r)
    else $error("step command produced no result");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_idle_r |-> out_x_r == '0 && out_y_r == '0 &&
      out_color_r == '0 && !out_vis_r && !out_last_r)
    else $error("idle result carries nonzero fields");

  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(active_r) |-> out_valid_r && out_last_r)
    else $error("line ended without a last pixel");

endmodule

// ===== sv/line_pixel_generator.sv =====
// Line pixel generator: Bresenham rasterizer, one pixel result per step beat.
// A step beat is written into the command queue and then into the result register.
// Throughput: one beat per cycle while the result register is free, set by the error update in lpg_back.
// A two-entry queue lets the request side run ahead while a result is held.
// Reset: screen 640 x 480, no line loaded, queue and result register empty.
module line_pixel_generator #(
  parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  lpg_in_if.sink   in_bus,
  lpg_out_if.source out_bus,
  lpg_cfg_if.sink  cfg_bus
);
  import lpg_pkg::*;

  localparam int CMD_W = cmd_bits(COORD_BITS);

  logic                   push_valid, push_ready, q_valid, q_pop;
  logic [CMD_W-1:0]       push_data, q_data;
  logic [SCREEN_BITS-1:0] width_r, width_nxt, height_r, height_nxt;

  assign cfg_bus.ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_bus.valid) begin
      case (cfg_reg_t'(cfg_bus.index))
        REG_SCREEN_WIDTH:  width_nxt  = cfg_bus.data;
        REG_SCREEN_HEIGHT: height_nxt = cfg_bus.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  lpg_front #(.COORD_BITS(COORD_BITS)) u_front (
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  lpg_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  lpg_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .screen_width  (width_r),
    .screen_height (height_r),
    .out_bus       (out_bus)
  );

endmodule

// ===== tb/tb_line_pixel_generator.sv =====
// Self-checking testbench for line_pixel_generator: directed rows, then random lines.
// Checks each pixel beat against an in-bench Bresenham predictor or, for typed directed rows, a fixed expected beat.
// Depends on lpg_pkg, the lpg_*_if interfaces and the line_pixel_generator RTL.
module tb_line_pixel_generator;
  import lpg_pkg::*;

  localparam int CB              = COORD_BITS_DEF;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int BEATS_PER_PHASE = 230;
  localparam int NUM_PHASES      = 6;

  typedef logic signed [CB-1:0] coord_t;

  typedef struct packed {
    req_type_t             kind;
    coord_t                sx;
    coord_t                sy;
    coord_t                ex;
    coord_t                ey;
    logic [COLOR_BITS-1:0] color;
  } line_req_t;

  typedef struct packed {
    coord_t                x;
    coord_t                y;
    logic [COLOR_BITS-1:0] color;
    logic                  visible;
    logic                  last;
    logic                  idle;
  } pixel_beat_t;

  typedef struct packed {
    line_req_t   req;
    logic        typed;
    pixel_beat_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lpg_in_if  #(.COORD_BITS(CB)) in_ch();
  lpg_out_if #(.COORD_BITS(CB)) out_ch();
  lpg_cfg_if                    cfg_ch();

  line_pixel_generator #(.COORD_BITS(CB)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_ch),
    .out_bus (out_ch),
    .cfg_bus (cfg_ch)
  );

  logic [SCREEN_BITS-1:0] scr_w;
  logic [SCREEN_BITS-1:0] scr_h;
  coord_t                 ln_x;
  coord_t                 ln_y;
  coord_t                 ln_gx;
  coord_t                 ln_gy;
  logic signed [CB:0]     ln_adx;
  logic signed [CB+1:0]   ln_nady;
  logic signed [CB+2:0]   ln_err;
  logic                   ln_xneg;
  logic                   ln_yneg;
  logic [COLOR_BITS-1:0]  ln_color;
  logic                   ln_live;

  pixel_beat_t pending_pixels[$];
  dir_row_t    dir_rows[$];
  int          err_cnt;
  int          sent_beats;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          phase_w[NUM_PHASES] = '{1, 32767, 0, 20, 32767, 0};
  int          phase_h[NUM_PHASES] = '{1, 32767, 480, 12, 1, 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic pixel_beat_t pix(input int x, input int y, input logic [31:0] c,
                                      input logic v, input logic l, input logic i);
    pixel_beat_t p;
    p.x       = coord_t'(x);
    p.y       = coord_t'(y);
    p.color   = c;
    p.visible = v;
    p.last    = l;
    p.idle    = i;
    return p;
  endfunction

  function automatic line_req_t load_req(input int sx, input int sy, input int ex,
                                         input int ey, input logic [31:0] c);
    line_req_t r;
    r.kind  = REQ_LOAD;
    r.sx    = coord_t'(sx);
    r.sy    = coord_t'(sy);
    r.ex    = coord_t'(ex);
    r.ey    = coord_t'(ey);
    r.color = c;
    return r;
  endfunction

  function automatic line_req_t step_req();
    line_req_t r;
    r.kind  = REQ_STEP;
    r.sx    = coord_t'($urandom);
    r.sy    = coord_t'($urandom);
    r.ex    = coord_t'($urandom);
    r.ey    = coord_t'($urandom);
    r.color = $urandom;
    return r;
  endfunction

  function automatic coord_t clamp_coord(input int v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  function automatic void clear_raster();
    scr_w    = WIDTH_RESET;
    scr_h    = HEIGHT_RESET;
    ln_x     = '0;
    ln_y     = '0;
    ln_gx    = '0;
    ln_gy    = '0;
    ln_adx   = '0;
    ln_nady  = '0;
    ln_err   = '0;
    ln_xneg  = 1'b0;
    ln_yneg  = 1'b0;
    ln_color = '0;
    ln_live  = 1'b0;
  endfunction

  // Returns 1 when the beat yields a pixel; advances the line state.
  function automatic logic raster_next(input line_req_t b, output pixel_beat_t px);
    int                 dxi;
    int                 dyi;
    logic signed [CB+3:0] e2;
    px = pix(0, 0, 0, 1'b0, 1'b0, 1'b0);
    if (b.kind == REQ_LOAD) begin
      dxi      = int'(b.ex) - int'(b.sx);
      dyi      = int'(b.ey) - int'(b.sy);
      ln_x     = b.sx;
      ln_y     = b.sy;
      ln_gx    = b.ex;
      ln_gy    = b.ey;
      ln_adx   = (CB+1)'((dxi < 0) ? -dxi : dxi);
      ln_nady  = (CB+2)'((dyi < 0) ? dyi : -dyi);
      ln_xneg  = !(b.sx < b.ex);
      ln_yneg  = !(b.sy < b.ey);
      ln_err   = ln_adx + ln_nady;
      ln_color = b.color;
      ln_live  = 1'b1;
      return 1'b0;
    end
    if (!ln_live) begin
      px.idle = 1'b1;
      return 1'b1;
    end
    px.x       = ln_x;
    px.y       = ln_y;
    px.color   = ln_color;
    px.visible = int'(ln_x) >= 0 && int'(ln_x) < int'(scr_w) &&
                 int'(ln_y) >= 0 && int'(ln_y) < int'(scr_h);
    px.last    = (ln_x == ln_gx) && (ln_y == ln_gy);
    if (px.last) begin
      ln_live = 1'b0;
    end else begin
      e2 = $signed({ln_err, 1'b0});
      if (e2 >= ln_nady) begin
        ln_err = ln_err + ln_nady;
        ln_x   = ln_xneg ? ln_x - coord_t'(1) : ln_x + coord_t'(1);
      end
      if (e2 <= ln_adx) begin
        ln_err = ln_err + ln_adx;
        ln_y   = ln_yneg ? ln_y - coord_t'(1) : ln_y + coord_t'(1);
      end
    end
    return 1'b1;
  endfunction

  function automatic void add_row(input line_req_t r, input logic typed, input pixel_beat_t w);
    dir_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = w;
    dir_rows.push_back(row);
  endfunction

  task automatic issue_beat(input line_req_t b, input logic typed, input pixel_beat_t want);
    pixel_beat_t px;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= b.kind;
    in_ch.start_x    <= b.sx;
    in_ch.start_y    <= b.sy;
    in_ch.end_x      <= b.ex;
    in_ch.end_y      <= b.ey;
    in_ch.line_color <= b.color;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (raster_next(b, px)) pending_pixels.push_back(typed ? want : px);
    sent_beats++;
  endtask

  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_screen(input logic [SCREEN_BITS-1:0] w,
                                input logic [SCREEN_BITS-1:0] h);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_SCREEN_WIDTH;
    cfg_ch.data  <= w;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    scr_w = w;
    cfg_ch.index <= REG_SCREEN_HEIGHT;
    cfg_ch.data  <= h;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    scr_h = h;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_lines(input int target);
    int     pick;
    int     span;
    int     nsteps;
    int     dx;
    int     dy;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    while (sent_beats < target) begin
      pick = $urandom_range(99);
      if (pick < 92) begin
        if ($urandom_range(1)) begin
          sx = clamp_coord(int'($urandom_range(int'(scr_w) + 8)) - 4);
          sy = clamp_coord(int'($urandom_range(int'(scr_h) + 8)) - 4);
        end else begin
          sx = coord_t'($urandom);
          sy = coord_t'($urandom);
        end
        if (pick < 80) begin
          span   = ($urandom_range(9) == 0) ? 200 : 10;
          ex     = clamp_coord(int'(sx) + int'($urandom_range(2 * span)) - span);
          ey     = clamp_coord(int'(sy) + int'($urandom_range(2 * span)) - span);
          dx     = int'(ex) - int'(sx);
          dy     = int'(ey) - int'(sy);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          nsteps = ((dx > dy) ? dx : dy) + 1 + (($urandom_range(9) < 3) ? 1 : 0);
        end else begin
          ex     = coord_t'($urandom);
          ey     = coord_t'($urandom);
          nsteps = $urandom_range(6);
        end
        issue_beat(load_req(sx, sy, ex, ey, $urandom), 1'b0, pix(0, 0, 0, 0, 0, 0));
        repeat (nsteps) issue_beat(step_req(), 1'b0, pix(0, 0, 0, 0, 0, 0));
      end else begin
        repeat ($urandom_range(3, 1)) issue_beat(step_req(), 1'b0, pix(0, 0, 0, 0, 0, 0));
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic check_pixel();
    pixel_beat_t want;
    if (pending_pixels.size() == 0) begin
      $display("%0t: unexpected pixel beat x=%h y=%h idle=%b", $time,
               out_ch.pixel_x, out_ch.pixel_y, out_ch.idle);
      err_cnt++;
    end else begin
      want = pending_pixels.pop_front();
      check_field("pixel_x", want.x, out_ch.pixel_x);
      check_field("pixel_y", want.y, out_ch.pixel_y);
      check_field("pixel_color", want.color, out_ch.pixel_color);
      check_field("visible", want.visible, out_ch.visible);
      check_field("last", want.last, out_ch.last);
      check_field("idle", want.idle, out_ch.idle);
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) check_pixel();
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_line_pixel_generator NOT OK");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_LOAD;
    in_ch.start_x    <= '0;
    in_ch.start_y    <= '0;
    in_ch.end_x      <= '0;
    in_ch.end_y      <= '0;
    in_ch.line_color <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_SCREEN_WIDTH;
    cfg_ch.data      <= '0;
    err_cnt          = 0;
    sent_beats       = 0;
    src_idle_pct     = 38;
    sink_idle_pct    = 46;
    clear_raster();

    add_row(step_req(), 1'b1, pix(0, 0, 0, 0, 0, 1));
    add_row(load_req(0, 0, 0, 0, 32'hFFFF_FFFF), 1'b0, pix(0, 0, 0, 0, 0, 0));
    add_row(step_req(), 1'b1, pix(0, 0, 32'hFFFF_FFFF, 1, 1, 0));
    add_row(step_req(), 1'b1, pix(0, 0, 0, 0, 0, 1));
    add_row(load_req(-32768, -32768, 32767, 32767, 32'h1234_5678), 1'b0, pix(0, 0, 0, 0, 0, 0));
    repeat (3) add_row(step_req(), 1'b0, pix(0, 0, 0, 0, 0, 0));
    add_row(load_req(32767, -32768, 32767, -32768, 32'h0), 1'b0, pix(0, 0, 0, 0, 0, 0));
    add_row(step_req(), 1'b1, pix(32767, -32768, 32'h0, 0, 1, 0));
    add_row(load_req(639, 479, 639, 479, 32'hA5A5_A5A5), 1'b0, pix(0, 0, 0, 0, 0, 0));
    add_row(step_req(), 1'b1, pix(639, 479, 32'hA5A5_A5A5, 1, 1, 0));
    add_row(load_req(640, 0, 640, 0, 32'h5A5A_5A5A), 1'b0, pix(0, 0, 0, 0, 0, 0));
    add_row(step_req(), 1'b1, pix(640, 0, 32'h5A5A_5A5A, 0, 1, 0));
    add_row(load_req(-1, -1, -1, -1, 32'hFFFF_0000), 1'b0, pix(0, 0, 0, 0, 0, 0));
    add_row(step_req(), 1'b1, pix(-1, -1, 32'hFFFF_0000, 0, 1, 0));
    add_row(load_req(-2, 3, 1, -1, 32'h00FF_00FF), 1'b0, pix(0, 0, 0, 0, 0, 0));
    repeat (5) add_row(step_req(), 1'b0, pix(0, 0, 0, 0, 0, 0));
    add_row(step_req(), 1'b1, pix(0, 0, 0, 0, 0, 1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) issue_beat(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    settle_block();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      src_idle_pct  = (ph < 2) ? 38 : (ph < 4) ? 46 : 0;
      sink_idle_pct = (ph < 2) ? 46 : (ph < 4) ? 38 : 0;
      if (ph == NUM_PHASES - 1)
        program_screen(SCREEN_BITS'($urandom_range(64, 1)),
                       SCREEN_BITS'($urandom_range(64, 1)));
      else
        program_screen(SCREEN_BITS'(phase_w[ph]), SCREEN_BITS'(phase_h[ph]));
      sent_beats = 0;
      run_lines(BEATS_PER_PHASE);
      settle_block();
    end

    if (err_cnt == 0)
      $display("tb_line_pixel_generator OK");
    else
      $display("tb_line_pixel_generator NOT OK");
    $finish;
  end

endmodule
